### design/tcps_pkg.sv
package tcps_pkg;

  localparam int NUM_CURVES = 8;
  localparam int BUF_DEPTH  = 64;

  localparam int MODE_W     = 2;
  localparam int CURVE_W    = 3;
  localparam int PCT_W      = 8;
  localparam int COORD_W    = 10;
  localparam int STEP_W     = 8;
  localparam int MAXP_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int CIDX_W  = (NUM_CURVES > 1) ? $clog2(NUM_CURVES) : 1;
  localparam int PTR_W   = $clog2(BUF_DEPTH);
  localparam int CNT_W   = $clog2(BUF_DEPTH + 1);
  localparam int SUM_W   = PTR_W + 1;
  localparam int MEM_DEPTH = NUM_CURVES * BUF_DEPTH;
  localparam int ADDR_W  = (MEM_DEPTH > 2) ? $clog2(MEM_DEPTH) : 1;
  localparam int X_W     = CNT_W + STEP_W + 1;

  // percent scaling: q = p / 100 via multiply by ceil(2^24 / 100)
  localparam int PCT_FULL = 100;
  localparam int PCT_C_W  = 7;
  localparam int PROD_W   = PCT_C_W + COORD_W;
  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = 18;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SH) + PCT_FULL - 1) / PCT_FULL);
  localparam int MIN_POINTS = 2;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_ADD       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DRAW_ALL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DRAW_LAST = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_Y_TOP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_BOTTOM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_LEFT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POINTS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_CLEAN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y     = 3'd6;

  localparam logic [COORD_W-1:0] RST_Y_TOP      = 10'd50;
  localparam logic [COORD_W-1:0] RST_Y_BOTTOM   = 10'd239;
  localparam logic [COORD_W-1:0] RST_X_LEFT     = 10'd0;
  localparam logic [STEP_W-1:0]  RST_STEP       = 8'd1;
  localparam logic [MAXP_W-1:0]  RST_MAX_POINTS = 7'd64;
  localparam logic               RST_FULL_CLEAN = 1'b1;
  localparam logic [COORD_W-1:0] RST_CLIP_Y     = 10'd50;

  // read index select
  localparam logic [1:0] RD_ZERO = 2'd0;
  localparam logic [1:0] RD_NEXT = 2'd1;
  localparam logic [1:0] RD_PEN  = 2'd2;
  localparam logic [1:0] RD_LAST = 2'd3;

  // segment shape while walking
  localparam logic SEG_STEP = 1'b0;
  localparam logic SEG_FLAT = 1'b1;

  // output source select
  localparam logic [1:0] OUT_TERM = 2'd0;
  localparam logic [1:0] OUT_DOT  = 2'd1;
  localparam logic [1:0] OUT_LAT  = 2'd2;
  localparam logic [1:0] OUT_PEND = 2'd3;

  typedef struct packed {
    logic       take_item;
    logic       add_mul;
    logic       add_div;
    logic       add_commit;
    logic       clr_commit;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       y0_cap;
    logic       run_inc;
    logic       advance;
    logic       push;
    logic       seg_kind;
    logic       out_load;
    logic [1:0] out_sel;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              bad;
    logic              cnt_zero;
    logic              cnt_one;
    logic              more;
    logic              eq;
    logic              run_zero;
    logic              clip_step;
    logic              clip_flat;
    logic              pend_v;
  } sts_t;

endpackage

### design/tcps_in_if.sv
interface tcps_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcps_pkg::MODE_W-1:0]  mode;
  logic [tcps_pkg::CURVE_W-1:0] curve;
  logic [tcps_pkg::PCT_W-1:0]   percent;

  modport source (output valid, output mode, output curve, output percent, input ready);
  modport sink   (input valid, input mode, input curve, input percent, output ready);
endinterface

### design/tcps_out_if.sv
interface tcps_out_if;
  logic                         valid;
  logic                         ready;
  logic                         seg_valid;
  logic [tcps_pkg::COORD_W-1:0] x_start;
  logic [tcps_pkg::COORD_W-1:0] y_start;
  logic [tcps_pkg::COORD_W-1:0] x_end;
  logic [tcps_pkg::COORD_W-1:0] y_end;
  logic                         last;

  modport source (output valid, output seg_valid, output x_start, output y_start,
                  output x_end, output y_end, output last, input ready);
  modport sink   (input valid, input seg_valid, input x_start, input y_start,
                  input x_end, input y_end, input last, output ready);
endinterface

### design/tcps_ctrl.sv
module tcps_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  tcps_pkg::sts_t sts,
  output tcps_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DEC     = 4'd1;
  localparam logic [3:0] S_ADD_DIV = 4'd2;
  localparam logic [3:0] S_ADD_WR  = 4'd3;
  localparam logic [3:0] S_DOT     = 4'd4;
  localparam logic [3:0] S_LAT0    = 4'd5;
  localparam logic [3:0] S_LAT1    = 4'd6;
  localparam logic [3:0] S_W0      = 4'd7;
  localparam logic [3:0] S_WCHK    = 4'd8;
  localparam logic [3:0] S_WCMP    = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       clipped;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == S_IDLE);
  assign clipped   = sts.run_zero ? sts.clip_step : sts.clip_flat;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_nxt     = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.mode)
          tcps_pkg::MODE_ADD: begin
            if (sts.bad) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.add_mul = 1'b1;
              state_nxt   = S_ADD_DIV;
            end
          end
          tcps_pkg::MODE_CLEAR: begin
            cmd.clr_commit = !sts.bad;
            state_nxt      = S_IDLE;
          end
          default: begin
            if (sts.bad || sts.cnt_zero) begin
              if (out_free) begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = tcps_pkg::OUT_TERM;
                cmd.out_last = 1'b1;
                state_nxt    = S_IDLE;
              end
            end else if (sts.cnt_one) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = tcps_pkg::RD_ZERO;
              state_nxt  = S_DOT;
            end else if (sts.mode == tcps_pkg::MODE_DRAW_LAST) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = tcps_pkg::RD_PEN;
              state_nxt  = S_LAT0;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = tcps_pkg::RD_ZERO;
              state_nxt  = S_W0;
            end
          end
        endcase
      end
      S_ADD_DIV: begin
        cmd.add_div = 1'b1;
        state_nxt   = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.add_commit = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_DOT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = tcps_pkg::OUT_DOT;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_LAT0: begin
        cmd.y0_cap = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = tcps_pkg::RD_LAST;
        state_nxt  = S_LAT1;
      end
      S_LAT1: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = tcps_pkg::OUT_LAT;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_W0: begin
        cmd.y0_cap = 1'b1;
        state_nxt  = S_WCHK;
      end
      S_WCHK: begin
        cmd.seg_kind = tcps_pkg::SEG_FLAT;
        if (sts.more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = tcps_pkg::RD_NEXT;
          state_nxt  = S_WCMP;
        end else if (sts.run_zero || sts.clip_flat) begin
          state_nxt = S_FIN;
        end else if (!sts.pend_v || out_free) begin
          // trailing flat run; the held segment goes out first
          cmd.push     = 1'b1;
          cmd.out_load = sts.pend_v;
          cmd.out_sel  = tcps_pkg::OUT_PEND;
          state_nxt    = S_FIN;
        end
      end
      S_WCMP: begin
        cmd.seg_kind = sts.run_zero ? tcps_pkg::SEG_STEP : tcps_pkg::SEG_FLAT;
        if (sts.eq) begin
          cmd.run_inc = 1'b1;
          state_nxt   = S_WCHK;
        end else if (clipped) begin
          state_nxt = S_FIN;
        end else if (!sts.pend_v || out_free) begin
          cmd.push     = 1'b1;
          cmd.advance  = 1'b1;
          cmd.out_load = sts.pend_v;
          cmd.out_sel  = tcps_pkg::OUT_PEND;
          state_nxt    = S_WCHK;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = sts.pend_v ? tcps_pkg::OUT_PEND : tcps_pkg::OUT_TERM;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/tcps_dp.sv
module tcps_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tcps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcps_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [tcps_pkg::MODE_W-1:0]        item_mode,
  input  logic [tcps_pkg::CURVE_W-1:0]       item_curve,
  input  logic [tcps_pkg::PCT_W-1:0]         item_percent,
  input  tcps_pkg::cmd_t                     cmd,
  output tcps_pkg::sts_t                     sts,
  output logic                               seg_valid,
  output logic [tcps_pkg::COORD_W-1:0]       x_start,
  output logic [tcps_pkg::COORD_W-1:0]       y_start,
  output logic [tcps_pkg::COORD_W-1:0]       x_end,
  output logic [tcps_pkg::COORD_W-1:0]       y_end,
  output logic                               last
);

  localparam int CW  = tcps_pkg::COORD_W;
  localparam int PW  = tcps_pkg::PTR_W;
  localparam int NW  = tcps_pkg::CNT_W;
  localparam int SW  = tcps_pkg::SUM_W;
  localparam int XW  = tcps_pkg::X_W;
  localparam int AW  = tcps_pkg::ADDR_W;
  localparam int QW  = tcps_pkg::PROD_W + tcps_pkg::RECIP_W;

  // configuration
  logic [CW-1:0]                   y_top_r, y_bottom_r, x_left_r, clip_y_r;
  logic [tcps_pkg::STEP_W-1:0]     step_r;
  logic [tcps_pkg::MAXP_W-1:0]     maxp_r;
  logic                            full_clean_r;

  // captured item
  logic [tcps_pkg::MODE_W-1:0]     mode_r;
  logic [tcps_pkg::CURVE_W-1:0]    curve_r;
  logic [tcps_pkg::PCT_W-1:0]      pct_r;

  // per-curve ring bookkeeping
  logic [PW-1:0]                   wp_r  [tcps_pkg::NUM_CURVES];
  logic [PW-1:0]                   op_r  [tcps_pkg::NUM_CURVES];
  logic [NW-1:0]                   cnt_r [tcps_pkg::NUM_CURVES];

  logic [CW-1:0]                   sample_mem_r [tcps_pkg::MEM_DEPTH];
  logic [CW-1:0]                   rdata_r;

  logic [tcps_pkg::PROD_W-1:0]     prod_r;
  logic [CW-1:0]                   quot_r;

  // walk
  logic [PW-1:0]                   i_r, run_r;
  logic [CW-1:0]                   y0_r;
  logic                            pend_v_r;
  logic [CW-1:0]                   pend_xs_r, pend_ys_r, pend_xe_r, pend_ye_r;

  logic [tcps_pkg::CIDX_W-1:0]     cidx;
  logic                            bad;
  logic [PW-1:0]                   wp_cur, op_cur;
  logic [NW-1:0]                   cnt_cur, m_eff, nxt_idx, ia, ib;
  logic [tcps_pkg::STEP_W-1:0]     st_eff;
  logic [PW-1:0]                   rd_idx, rd_slot, wr_slot;
  logic [SW-1:0]                   rd_sum, wp_sum, op_sum;
  logic [AW-1:0]                   rd_addr, wr_addr;
  logic                            full;
  logic [PW-1:0]                   wp_new, op_new, op_inc;
  logic [NW-1:0]                   cnt_new;
  logic [CW-1:0]                   diff, y_new, cand_y1, xa_sat, xb_sat;
  logic [tcps_pkg::PCT_C_W-1:0]    pct_c;
  logic [QW-1:0]                   qprod;
  logic [XW-1:0]                   xa, xb;
  logic                            lat;

  assign cidx    = curve_r[tcps_pkg::CIDX_W-1:0];
  assign bad     = int'(curve_r) >= tcps_pkg::NUM_CURVES;
  assign wp_cur  = wp_r[cidx];
  assign op_cur  = op_r[cidx];
  assign cnt_cur = cnt_r[cidx];
  assign st_eff  = (step_r == '0) ? tcps_pkg::STEP_W'(1) : step_r;
  assign lat     = (mode_r == tcps_pkg::MODE_DRAW_LAST);

  always_comb begin
    if (maxp_r < tcps_pkg::MAXP_W'(tcps_pkg::MIN_POINTS)) begin
      m_eff = NW'(tcps_pkg::MIN_POINTS);
    end else if (maxp_r > tcps_pkg::MAXP_W'(tcps_pkg::BUF_DEPTH)) begin
      m_eff = NW'(tcps_pkg::BUF_DEPTH);
    end else begin
      m_eff = NW'(maxp_r);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_top_r      <= tcps_pkg::RST_Y_TOP;
      y_bottom_r   <= tcps_pkg::RST_Y_BOTTOM;
      x_left_r     <= tcps_pkg::RST_X_LEFT;
      step_r       <= tcps_pkg::RST_STEP;
      maxp_r       <= tcps_pkg::RST_MAX_POINTS;
      full_clean_r <= tcps_pkg::RST_FULL_CLEAN;
      clip_y_r     <= tcps_pkg::RST_CLIP_Y;
    end else if (cfg_we) begin
      case (cfg_index)
        tcps_pkg::REG_Y_TOP:      y_top_r      <= cfg_data;
        tcps_pkg::REG_Y_BOTTOM:   y_bottom_r   <= cfg_data;
        tcps_pkg::REG_X_LEFT:     x_left_r     <= cfg_data;
        tcps_pkg::REG_STEP:       step_r       <= cfg_data[tcps_pkg::STEP_W-1:0];
        tcps_pkg::REG_MAX_POINTS: maxp_r       <= cfg_data[tcps_pkg::MAXP_W-1:0];
        tcps_pkg::REG_FULL_CLEAN: full_clean_r <= cfg_data[0];
        tcps_pkg::REG_CLIP_Y:     clip_y_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      mode_r  <= item_mode;
      curve_r <= item_curve;
      pct_r   <= item_percent;
    end
  end

  // y = bottom -/+ pct * |bottom - top| / 100, three registered steps
  assign diff  = (y_bottom_r >= y_top_r) ? (y_bottom_r - y_top_r) : (y_top_r - y_bottom_r);
  assign pct_c = (pct_r > tcps_pkg::PCT_W'(tcps_pkg::PCT_FULL)) ?
                 tcps_pkg::PCT_C_W'(tcps_pkg::PCT_FULL) : pct_r[tcps_pkg::PCT_C_W-1:0];
  assign qprod = QW'(prod_r) * QW'(tcps_pkg::RECIP);
  assign y_new = (y_bottom_r >= y_top_r) ? (y_bottom_r - quot_r) : (y_bottom_r + quot_r);

  always_ff @(posedge clk) begin
    if (cmd.add_mul) begin
      prod_r <= tcps_pkg::PROD_W'(pct_c) * tcps_pkg::PROD_W'(diff);
    end
    if (cmd.add_div) begin
      quot_r <= qprod[tcps_pkg::RECIP_SH +: CW];
    end
  end

  // add bookkeeping
  assign full    = (cnt_cur >= m_eff);
  assign wr_slot = (full && full_clean_r) ? '0 : wp_cur;
  assign wp_sum  = SW'(wr_slot) + SW'(1);
  assign wp_new  = (wp_sum >= SW'(m_eff)) ? '0 : wp_sum[PW-1:0];
  assign op_sum  = SW'(op_cur) + SW'(1);
  assign op_inc  = (op_sum >= SW'(m_eff)) ? '0 : op_sum[PW-1:0];

  always_comb begin
    if (!full) begin
      op_new  = op_cur;
      cnt_new = cnt_cur + NW'(1);
    end else if (full_clean_r) begin
      op_new  = '0;
      cnt_new = NW'(1);
    end else begin
      op_new  = op_inc;
      cnt_new = cnt_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (cfg_we && (cfg_index == tcps_pkg::REG_MAX_POINTS))) begin
      for (int c = 0; c < tcps_pkg::NUM_CURVES; c++) begin
        wp_r[c]  <= '0;
        op_r[c]  <= '0;
        cnt_r[c] <= '0;
      end
    end else if (cmd.add_commit) begin
      wp_r[cidx]  <= wp_new;
      op_r[cidx]  <= op_new;
      cnt_r[cidx] <= cnt_new;
    end else if (cmd.clr_commit) begin
      wp_r[cidx]  <= '0;
      op_r[cidx]  <= '0;
      cnt_r[cidx] <= '0;
    end
  end

  // read side: logical index -> ring slot
  assign nxt_idx = NW'(i_r) + NW'(run_r) + NW'(1);

  always_comb begin
    unique case (cmd.rd_sel)
      tcps_pkg::RD_ZERO: rd_idx = '0;
      tcps_pkg::RD_NEXT: rd_idx = nxt_idx[PW-1:0];
      tcps_pkg::RD_PEN:  rd_idx = PW'(cnt_cur - NW'(2));
      default:           rd_idx = PW'(cnt_cur - NW'(1));
    endcase
  end

  assign rd_sum  = SW'(op_cur) + SW'(rd_idx);
  assign rd_slot = (rd_sum >= SW'(m_eff)) ? PW'(rd_sum - SW'(m_eff)) : rd_sum[PW-1:0];
  assign rd_addr = AW'(int'(cidx) * tcps_pkg::BUF_DEPTH) + AW'(rd_slot);
  assign wr_addr = AW'(int'(cidx) * tcps_pkg::BUF_DEPTH) + AW'(wr_slot);

  always_ff @(posedge clk) begin
    if (cmd.add_commit) begin
      sample_mem_r[wr_addr] <= y_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= sample_mem_r[rd_addr];
    end
  end

  // candidate segment and its columns
  assign cand_y1 = (cmd.seg_kind == tcps_pkg::SEG_STEP) ? rdata_r : y0_r;

  always_comb begin
    if (lat) begin
      ia = cnt_cur - NW'(2);
      ib = cnt_cur - NW'(1);
    end else begin
      ia = NW'(i_r);
      ib = (cmd.seg_kind == tcps_pkg::SEG_STEP) ? (NW'(i_r) + NW'(1)) :
                                                  (NW'(i_r) + NW'(run_r));
    end
  end

  assign xa     = XW'(x_left_r) + XW'(ia) * XW'(st_eff);
  assign xb     = XW'(x_left_r) + XW'(ib) * XW'(st_eff);
  assign xa_sat = (xa > XW'(tcps_pkg::COORD_MAX)) ? tcps_pkg::COORD_MAX : xa[CW-1:0];
  assign xb_sat = (xb > XW'(tcps_pkg::COORD_MAX)) ? tcps_pkg::COORD_MAX : xb[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.y0_cap) begin
      pend_v_r <= 1'b0;
    end else if (cmd.push) begin
      pend_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.y0_cap) begin
      y0_r  <= rdata_r;
      i_r   <= '0;
      run_r <= '0;
    end else begin
      if (cmd.run_inc) begin
        run_r <= run_r + PW'(1);
      end
      if (cmd.advance) begin
        run_r <= '0;
        if (cmd.seg_kind == tcps_pkg::SEG_STEP) begin
          i_r  <= i_r + PW'(1);
          y0_r <= rdata_r;
        end else begin
          i_r <= i_r + run_r;
        end
      end
    end
    if (cmd.push) begin
      pend_xs_r <= xa_sat;
      pend_ys_r <= y0_r;
      pend_xe_r <= xb_sat;
      pend_ye_r <= cand_y1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      last <= cmd.out_last;
      unique case (cmd.out_sel)
        tcps_pkg::OUT_TERM: begin
          seg_valid <= 1'b0;
          x_start   <= '0;
          y_start   <= '0;
          x_end     <= '0;
          y_end     <= '0;
        end
        tcps_pkg::OUT_DOT: begin
          seg_valid <= 1'b1;
          x_start   <= x_left_r;
          y_start   <= rdata_r;
          x_end     <= x_left_r;
          y_end     <= rdata_r;
        end
        tcps_pkg::OUT_LAT: begin
          seg_valid <= 1'b1;
          x_start   <= xa_sat;
          y_start   <= y0_r;
          x_end     <= xb_sat;
          y_end     <= rdata_r;
        end
        default: begin
          seg_valid <= 1'b1;
          x_start   <= pend_xs_r;
          y_start   <= pend_ys_r;
          x_end     <= pend_xe_r;
          y_end     <= pend_ye_r;
        end
      endcase
    end
  end

  assign sts.mode      = mode_r;
  assign sts.bad       = bad;
  assign sts.cnt_zero  = (cnt_cur == '0);
  assign sts.cnt_one   = (cnt_cur == NW'(1));
  assign sts.more      = (nxt_idx < cnt_cur);
  assign sts.eq        = (rdata_r == y0_r);
  assign sts.run_zero  = (run_r == '0);
  assign sts.clip_step = (y0_r < clip_y_r) || (rdata_r < clip_y_r);
  assign sts.clip_flat = (y0_r < clip_y_r);
  assign sts.pend_v    = pend_v_r;

endmodule

### design/trend_curve_point_store_unit.sv
// An add is stored after acceptance in the steps multiply, scale, write; a clear in decode.
// A draw answers an empty curve from decode, a single point after one read, latest after two
// reads; a draw-all of n points walks them with a read plus a compare per point, its results
// going out one segment behind.
// One item at a time: the next item is accepted the cycle after an item finishes; output
// stalls lengthen an item. Sync reset (rst_n low): register defaults, every curve empty, memory kept.
module trend_curve_point_store_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  tcps_in_if.sink                         in_ch,
  tcps_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [tcps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcps_pkg::CFG_DATA_W-1:0] cfg_data
);

  tcps_pkg::cmd_t cmd;
  tcps_pkg::sts_t sts;

  tcps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcps_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_mode    (in_ch.mode),
    .item_curve   (in_ch.curve),
    .item_percent (in_ch.percent),
    .cmd          (cmd),
    .sts          (sts),
    .seg_valid    (out_ch.seg_valid),
    .x_start      (out_ch.x_start),
    .y_start      (out_ch.y_start),
    .x_end        (out_ch.x_end),
    .y_end        (out_ch.y_end),
    .last         (out_ch.last)
  );

  // one item at a time: an accepted item makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while previous item still in work");

  // an empty result only ever closes a draw
  a_term_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.seg_valid |-> out_ch.last)
    else $error("empty result without last");

  a_reset_no_output: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result pending after reset");

  // a segment from a walk never runs backwards in x
  a_x_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.seg_valid |-> out_ch.x_end >= out_ch.x_start)
    else $error("segment end column before start column");

endmodule
